### sv/dhcp6x_pkg.sv
// dhcp6x_pkg: shared types and constants for the DHCPv6 option extractor.
// Beat structs, parse phase encoding and option codes.
// No dependencies.
package dhcp6x_pkg;

    localparam int MSG_BYTES_DEF = 2048;
    localparam int FLD_W         = 11;

    localparam logic [15:0] OPT_CLIENT_ID = 16'd1;
    localparam logic [15:0] OPT_SERVER_ID = 16'd2;
    localparam logic [15:0] OPT_IA_NA     = 16'd3;

    localparam logic [1:0] IDX_CID = 2'd0;
    localparam logic [1:0] IDX_SID = 2'd1;
    localparam logic [1:0] IDX_IA  = 2'd2;

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_CODE_HI = 6'b000010,
        PH_CODE_LO = 6'b000100,
        PH_LEN_HI  = 6'b001000,
        PH_LEN_LO  = 6'b010000,
        PH_BODY    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic             msg_ok;
        logic [7:0]       msg_type;
        logic [23:0]      xid;
        logic [FLD_W-1:0] cid_offset;
        logic [FLD_W-1:0] cid_len;
        logic             sid_found;
        logic [FLD_W-1:0] sid_offset;
        logic [FLD_W-1:0] sid_len;
        logic             iaid_found;
        logic [31:0]      iaid;
    } t_out_beat;

endpackage

### sv/dhcp6x_parse.sv
// dhcp6x_parse: per-message parse state and TLV walk.
// Updates state on each stepped beat; o_res is the summary including that beat.
// Depends on dhcp6x_pkg.
module dhcp6x_parse
    import dhcp6x_pkg::*;
#(
    parameter int MAX_MSG_BYTES = MSG_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_beat  i_beat,
    output t_out_beat o_res
);

    localparam int POS_W = $clog2(MAX_MSG_BYTES + 1);
    localparam int AW    = (POS_W > 16) ? POS_W : 16;

    logic [POS_W-1:0] r_pos, n_pos;
    t_phase           r_phase, n_phase;
    logic [15:0]      r_code, n_code;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_rem, n_rem;
    logic [31:0]      r_hdr, n_hdr;
    logic [2:0]       r_found, n_found;
    logic [FLD_W-1:0] r_off [3];
    logic [FLD_W-1:0] n_off [3];
    logic [FLD_W-1:0] r_ln  [3];
    logic [FLD_W-1:0] n_ln  [3];
    logic [31:0]      r_iaid, n_iaid;

    logic [15:0]      len_full;
    logic [15:0]      idx;
    logic             done;
    logic [AW-1:0]    start;
    logic [1:0]       k;
    logic             hdr_ok;
    logic             ia_ok;

    always_comb begin
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_code   = r_code;
        n_len    = r_len;
        n_rem    = r_rem;
        n_hdr    = r_hdr;
        n_found  = r_found;
        n_off    = r_off;
        n_ln     = r_ln;
        n_iaid   = r_iaid;
        len_full = {r_len[15:8], i_beat.data_byte};
        idx      = r_len - r_rem;
        done     = 1'b0;
        start    = AW'(r_pos) + AW'(1) - AW'(n_len);
        k        = r_code[1:0] - 2'd1;
        if (r_pos != POS_W'(MAX_MSG_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
            unique case (r_phase)
                PH_HEADER: begin
                    n_hdr = {r_hdr[23:0], i_beat.data_byte};
                    if (r_pos == POS_W'(3)) n_phase = PH_CODE_HI;
                end
                PH_CODE_HI: begin
                    n_code  = {i_beat.data_byte, 8'h00};
                    n_phase = PH_CODE_LO;
                end
                PH_CODE_LO: begin
                    n_code  = {r_code[15:8], i_beat.data_byte};
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len   = {i_beat.data_byte, 8'h00};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len = len_full;
                    n_rem = len_full;
                    if (r_code == OPT_IA_NA && !r_found[IDX_IA]) n_iaid = '0;
                    if (len_full == 16'd0) done = 1'b1;
                    else n_phase = PH_BODY;
                end
                PH_BODY: begin
                    if (r_code == OPT_IA_NA && !r_found[IDX_IA] && idx < 16'd4)
                        n_iaid = {r_iaid[23:0], i_beat.data_byte};
                    n_rem = r_rem - 16'd1;
                    if (n_rem == 16'd0) done = 1'b1;
                end
                default: n_phase = PH_CODE_HI;
            endcase
            start = AW'(r_pos) + AW'(1) - AW'(n_len);
            if (done) begin
                n_phase = PH_CODE_HI;
                if (r_code == OPT_CLIENT_ID || r_code == OPT_SERVER_ID ||
                    r_code == OPT_IA_NA) begin
                    if (!r_found[k]) begin
                        n_found[k] = 1'b1;
                        n_off[k]   = start[FLD_W-1:0];
                        n_ln[k]    = n_len[FLD_W-1:0];
                    end
                end
            end
        end
    end

    always_comb begin
        hdr_ok = (n_phase != PH_HEADER);
        ia_ok  = n_found[IDX_IA] && (n_ln[IDX_IA] >= FLD_W'(4));
        o_res.msg_ok     = hdr_ok && n_found[IDX_CID];
        o_res.msg_type   = hdr_ok ? n_hdr[31:24] : 8'h00;
        o_res.xid        = hdr_ok ? n_hdr[23:0] : 24'h0;
        o_res.cid_offset = n_found[IDX_CID] ? n_off[IDX_CID] : '0;
        o_res.cid_len    = n_found[IDX_CID] ? n_ln[IDX_CID] : '0;
        o_res.sid_found  = n_found[IDX_SID];
        o_res.sid_offset = n_found[IDX_SID] ? n_off[IDX_SID] : '0;
        o_res.sid_len    = n_found[IDX_SID] ? n_ln[IDX_SID] : '0;
        o_res.iaid_found = ia_ok;
        o_res.iaid       = ia_ok ? n_iaid : 32'h0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_HEADER;
            r_found <= '0;
        end else if (i_step) begin
            if (i_beat.last_byte) begin
                r_pos   <= '0;
                r_phase <= PH_HEADER;
                r_found <= '0;
            end else begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_found <= n_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_code <= n_code;
            r_len  <= n_len;
            r_rem  <= n_rem;
            r_hdr  <= n_hdr;
            r_off  <= n_off;
            r_ln   <= n_ln;
            r_iaid <= n_iaid;
        end
    end

`ifndef ASSERT_OFF
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase)) else $error("parse phase not one-hot");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_MSG_BYTES)) else $error("byte position past limit");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_beat.last_byte |=> r_pos == '0 && r_phase == PH_HEADER && r_found == '0)
        else $error("state not cleared after last beat");
    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && i_beat.last_byte) |=> (r_found & $past(r_found)) == $past(r_found))
        else $error("found flag dropped mid-message");
    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_pos <= POS_W'(3))
        else $error("header phase beyond fourth byte");
`endif

endmodule

### sv/dhcpv6_option_extractor.sv
// Result path: the last byte is held in the input register, then its result is registered in the result register.
// Throughput: one byte per cycle while no last byte stalls; one result per message on its last byte.
// A last byte stalls in the input register only while a prior result is not taken.
// Reset: synchronous active-low; clears handshakes and returns parser to header phase.
// Depends on dhcp6x_pkg and dhcp6x_parse.
module dhcpv6_option_extractor
    import dhcp6x_pkg::*;
#(
    parameter int MAX_MSG_BYTES = MSG_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic      r_in_v;
    t_in_beat  r_in;
    logic      r_out_v;
    t_out_beat r_out;
    logic      advance;
    t_out_beat res;

    assign advance     = r_in_v && (!r_in.last_byte || !r_out_v || i_out_ready);
    assign o_in_ready  = !r_in_v || advance;
    assign o_out_valid = r_out_v;
    assign o_out_beat  = r_out;

    dhcp6x_parse #(
        .MAX_MSG_BYTES(MAX_MSG_BYTES)
    ) u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (advance),
        .i_beat (r_in),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_in_ready) r_in_v <= i_in_valid;
            if (advance && r_in.last_byte) r_out_v <= 1'b1;
            else if (i_out_ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in <= i_in_beat;
        if (advance && r_in.last_byte) r_out <= res;
    end

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |-> o_in_ready) else $error("input stalled with empty output");
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_v && r_in.last_byte))
        else $error("result without last beat");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !i_out_ready |-> !(advance && r_in.last_byte))
        else $error("pending result overwritten");
`endif

endmodule
